// ===== sv/jst_pkg.sv =====
// ============================================================================
// jst_pkg
// Command, status and sequencer state codes shared by the job slot table.
// ============================================================================
package jst_pkg;

    localparam int CMD_W    = 4;
    localparam int PID_W    = 22;
    localparam int SID_W    = 7;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 8;

    localparam logic [CMD_W-1:0] CMD_ADD       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_RM_SLOT   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RM_KEY    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_STOP_KEY  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_RUN_KEY   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_STOP_SLOT = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RUN_SLOT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_LOOK_SLOT = 4'd7;
    localparam logic [CMD_W-1:0] CMD_LOOK_KEY  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_TOP       = 4'd9;
    localparam logic [CMD_W-1:0] CMD_TOP_STOP  = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_SLOT_CHK = 5'b00100,
        S_SCAN     = 5'b01000,
        S_DONE     = 5'b10000
    } jst_state_t;

endpackage

// ===== sv/jst_cmd_if.sv =====
// ============================================================================
// jst_cmd_if
// Command channel of the job slot table: valid/ready plus one command item.
// ============================================================================
interface jst_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [jst_pkg::CMD_W-1:0]  command;
    logic [jst_pkg::PID_W-1:0]  job_pid;
    logic [jst_pkg::SID_W-1:0]  slot_id;

    modport source (output valid, command, job_pid, slot_id, input ready);
    modport sink   (input valid, command, job_pid, slot_id, output ready);
endinterface

// ===== sv/jst_rsp_if.sv =====
// ============================================================================
// jst_rsp_if
// Result channel of the job slot table: valid/ready plus one result item.
// ============================================================================
interface jst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [jst_pkg::STATUS_W-1:0]  status;
    logic [jst_pkg::SID_W-1:0]     found_slot;
    logic [jst_pkg::PID_W-1:0]     found_pid;
    logic                          found_stopped;
    logic [jst_pkg::HELD_W-1:0]    jobs_held;

    modport source (output valid, status, found_slot, found_pid, found_stopped, jobs_held,
                    input ready);
    modport sink   (input valid, status, found_slot, found_pid, found_stopped, jobs_held,
                    output ready);
endinterface

// ===== sv/job_slot_table_core.sv =====
// ============================================================================
// job_slot_table_core
// Table of SLOTS job slots: add to lowest free slot, remove, stop, run and
// look up by slot or key, report highest used or stopped slot.
//
// One item at a time. After reset a clearing pass writes every slot before
// the first item is taken. Operations by slot read only the addressed slot.
// Add, operations by key and the top queries walk the table one slot per
// cycle through the single read port of the slot memory (add scans from the
// new slot up to the next free one; by-key stops at the first match; top
// queries always read all slots). Unknown commands, a slot number out of
// range and a full table answer without a walk. The result sits in an output
// register; the next item is taken once the result is handed off to it.
// ============================================================================
module job_slot_table_core #(
    parameter int SLOTS    = 128,
    parameter int KEY_BITS = 22
) (
    input  logic       clk,
    input  logic       rst_n,
    jst_cmd_if.sink    cmd,
    jst_rsp_if.source  rsp
);

    localparam int SW     = $clog2(SLOTS);
    localparam int IW     = SW + 1;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int EW     = KEY_BITS + 2;
    localparam int USED_B = KEY_BITS + 1;
    localparam int STOP_B = KEY_BITS;

    jst_pkg::jst_state_t state_reg, state_next;

    logic [jst_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [SW-1:0]                tgt_reg, tgt_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [SW-1:0]                chk_idx_reg, chk_idx_next;
    logic                         chk_vld_reg, chk_vld_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [IW-1:0]                low_free_reg, low_free_next;
    logic [jst_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]                res_slot_reg, res_slot_next;
    logic [KEY_BITS-1:0]          res_pid_reg, res_pid_next;
    logic                         res_stop_reg, res_stop_next;
    logic                         out_valid_reg, out_valid_next;
    logic [jst_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [jst_pkg::SID_W-1:0]    out_slot_reg, out_slot_next;
    logic [jst_pkg::PID_W-1:0]    out_pid_reg, out_pid_next;
    logic                         out_stop_reg, out_stop_next;
    logic [jst_pkg::HELD_W-1:0]   out_held_reg, out_held_next;

    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [SW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic                ent_used;
    logic                ent_stop;
    logic [KEY_BITS-1:0] ent_pid;
    logic [KEY_BITS-1:0] key_in;
    logic                cmd_acc;
    logic                app_en;
    logic [SW-1:0]       app_idx;

    jst_mem #(
        .DEPTH (SLOTS),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign ent_used = mem_rdata[USED_B];
    assign ent_stop = mem_rdata[STOP_B];
    assign ent_pid  = mem_rdata[KEY_BITS-1:0];
    assign key_in   = KEY_BITS'(cmd.job_pid);

    assign cmd.ready = (state_reg == jst_pkg::S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found_slot    = out_slot_reg;
    assign rsp.found_pid     = out_pid_reg;
    assign rsp.found_stopped = out_stop_reg;
    assign rsp.jobs_held     = out_held_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        tgt_next        = tgt_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        count_next      = count_reg;
        low_free_next   = low_free_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pid_next    = res_pid_reg;
        res_stop_next   = res_stop_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_pid_next    = out_pid_reg;
        out_stop_next   = out_stop_reg;
        out_held_next   = out_held_reg;

        mem_we    = 1'b0;
        mem_waddr = idx_reg[SW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[SW-1:0];
        app_en    = 1'b0;
        app_idx   = tgt_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            jst_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[SW-1:0];
                mem_wdata = '0;
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    idx_next   = '0;
                    state_next = jst_pkg::S_IDLE;
                end
            end

            jst_pkg::S_IDLE:
            begin
                if (cmd_acc)
                begin
                    cmd_next        = cmd.command;
                    key_next        = key_in;
                    tgt_next        = SW'(cmd.slot_id);
                    res_status_next = jst_pkg::ST_NONE;
                    res_slot_next   = '0;
                    res_pid_next    = '0;
                    res_stop_next   = 1'b0;
                    chk_vld_next    = 1'b0;
                    idx_next        = '0;
                    state_next      = jst_pkg::S_DONE;
                    case (cmd.command)
                        jst_pkg::CMD_ADD:
                        begin
                            if (count_reg >= CW'(SLOTS) || low_free_reg >= IW'(SLOTS))
                            begin
                                res_status_next = jst_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = low_free_reg[SW-1:0];
                                mem_wdata       = {1'b1, 1'b0, key_in};
                                res_status_next = jst_pkg::ST_OK;
                                res_slot_next   = low_free_reg[SW-1:0];
                                res_pid_next    = key_in;
                                count_next      = count_reg + CW'(1);
                                idx_next        = low_free_reg + IW'(1);
                                state_next      = jst_pkg::S_SCAN;
                            end
                        end
                        jst_pkg::CMD_RM_SLOT, jst_pkg::CMD_STOP_SLOT,
                        jst_pkg::CMD_RUN_SLOT, jst_pkg::CMD_LOOK_SLOT:
                        begin
                            if (32'(cmd.slot_id) < 32'(SLOTS))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = SW'(cmd.slot_id);
                                state_next = jst_pkg::S_SLOT_CHK;
                            end
                        end
                        jst_pkg::CMD_RM_KEY, jst_pkg::CMD_STOP_KEY,
                        jst_pkg::CMD_RUN_KEY, jst_pkg::CMD_LOOK_KEY,
                        jst_pkg::CMD_TOP, jst_pkg::CMD_TOP_STOP:
                        begin
                            state_next = jst_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = jst_pkg::S_DONE;
                        end
                    endcase
                end
            end

            jst_pkg::S_SLOT_CHK:
            begin
                if (ent_used)
                begin
                    app_en  = 1'b1;
                    app_idx = tgt_reg;
                end
                else
                begin
                    state_next = jst_pkg::S_DONE;
                end
            end

            jst_pkg::S_SCAN:
            begin
                if (idx_reg < IW'(SLOTS))
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = idx_reg[SW-1:0];
                    idx_next     = idx_reg + IW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[SW-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg)
                begin
                    case (cmd_reg)
                        jst_pkg::CMD_ADD:
                        begin
                            if (!ent_used)
                            begin
                                low_free_next = {1'b0, chk_idx_reg};
                                state_next    = jst_pkg::S_DONE;
                            end
                        end
                        jst_pkg::CMD_TOP, jst_pkg::CMD_TOP_STOP:
                        begin
                            if (ent_used && (cmd_reg == jst_pkg::CMD_TOP || ent_stop))
                            begin
                                res_status_next = jst_pkg::ST_OK;
                                res_slot_next   = chk_idx_reg;
                                res_pid_next    = ent_pid;
                                res_stop_next   = ent_stop;
                            end
                        end
                        default:
                        begin
                            if (ent_used && ent_pid == key_reg)
                            begin
                                app_en  = 1'b1;
                                app_idx = chk_idx_reg;
                            end
                        end
                    endcase
                end
                else if (idx_reg >= IW'(SLOTS))
                begin
                    if (cmd_reg == jst_pkg::CMD_ADD)
                    begin
                        low_free_next = IW'(SLOTS);
                    end
                    state_next = jst_pkg::S_DONE;
                end
            end

            jst_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = jst_pkg::SID_W'(res_slot_reg);
                    out_pid_next    = jst_pkg::PID_W'(res_pid_reg);
                    out_stop_next   = res_stop_reg;
                    out_held_next   = jst_pkg::HELD_W'(count_reg);
                    state_next      = jst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = jst_pkg::S_IDLE;
            end
        endcase

        // apply the command to the selected used slot
        if (app_en)
        begin
            mem_we          = 1'b1;
            mem_waddr       = app_idx;
            res_status_next = jst_pkg::ST_OK;
            res_slot_next   = app_idx;
            res_pid_next    = ent_pid;
            res_stop_next   = ent_stop;
            state_next      = jst_pkg::S_DONE;
            case (cmd_reg)
                jst_pkg::CMD_RM_SLOT, jst_pkg::CMD_RM_KEY:
                begin
                    mem_wdata  = {1'b0, 1'b0, ent_pid};
                    count_next = count_reg - CW'(1);
                    if ({1'b0, app_idx} < low_free_reg)
                    begin
                        low_free_next = {1'b0, app_idx};
                    end
                end
                jst_pkg::CMD_STOP_SLOT, jst_pkg::CMD_STOP_KEY:
                begin
                    mem_wdata     = {1'b1, 1'b1, ent_pid};
                    res_stop_next = 1'b1;
                end
                jst_pkg::CMD_RUN_SLOT, jst_pkg::CMD_RUN_KEY:
                begin
                    mem_wdata     = {1'b1, 1'b0, ent_pid};
                    res_stop_next = 1'b0;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= jst_pkg::S_CLEAR;
            cmd_reg        <= '0;
            key_reg        <= '0;
            tgt_reg        <= '0;
            idx_reg        <= '0;
            chk_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            count_reg      <= '0;
            low_free_reg   <= '0;
            res_status_reg <= '0;
            res_slot_reg   <= '0;
            res_pid_reg    <= '0;
            res_stop_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_slot_reg   <= '0;
            out_pid_reg    <= '0;
            out_stop_reg   <= 1'b0;
            out_held_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            tgt_reg        <= tgt_next;
            idx_reg        <= idx_next;
            chk_idx_reg    <= chk_idx_next;
            chk_vld_reg    <= chk_vld_next;
            count_reg      <= count_next;
            low_free_reg   <= low_free_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_pid_reg    <= res_pid_next;
            res_stop_reg   <= res_stop_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_pid_reg    <= out_pid_next;
            out_stop_reg   <= out_stop_next;
            out_held_reg   <= out_held_next;
        end
    end

endmodule

// ===== sv/jst_mem.sv =====
// ============================================================================
// jst_mem
// Slot table storage: one write port, one read port with registered data.
// ============================================================================
module jst_mem #(
    parameter  int DEPTH = 128,
    parameter  int WIDTH = 24,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/tb_job_slot_table_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_job_slot_table_core
// Self-checking bench for the job slot table. Commands go in over the command
// channel. A shadow copy of the table predicts each result at the moment the
// command is accepted. Results are checked in order, field by field. A short
// directed pass covers the empty table, adds, duplicate keys, by-slot and
// by-key operations, top queries and unused codes. Fill bursts run the table
// full. A random mix then works mostly on live slots and stored keys. The
// sender and receiver idle at different rates as the run goes on.
// ============================================================================
module tb_job_slot_table_core;

    localparam int TBL_SLOTS    = 128;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES  = TBL_SLOTS + 64;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [jst_pkg::PID_W-1:0] PID_MAX       = {jst_pkg::PID_W{1'b1}};
    localparam logic [jst_pkg::SID_W-1:0] SID_MAX       = {jst_pkg::SID_W{1'b1}};
    localparam logic [jst_pkg::CMD_W-1:0] CMD_LAST_CODE = {jst_pkg::CMD_W{1'b1}};

    typedef struct packed {
        logic [jst_pkg::STATUS_W-1:0] status;
        logic [jst_pkg::SID_W-1:0]    slot;
        logic [jst_pkg::PID_W-1:0]    pid;
        logic                         stopped;
        logic [jst_pkg::HELD_W-1:0]   held;
    } job_result_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic rcv_ready = 1'b0;

    jst_cmd_if cmd_if ();
    jst_rsp_if rsp_if ();

    assign rsp_if.ready = rcv_ready;

    job_slot_table_core #(
        .SLOTS    (TBL_SLOTS),
        .KEY_BITS (jst_pkg::PID_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // shadow table
    logic                      tbl_used    [TBL_SLOTS];
    logic [jst_pkg::PID_W-1:0] tbl_pid     [TBL_SLOTS];
    logic                      tbl_stopped [TBL_SLOTS];
    int                        tbl_held;
    int                        tbl_low_free;

    job_result_t results_due [$];
    job_result_t want_res;

    int send_idle_pct   = 0;
    int rcv_idle_pct    = 0;
    int errors          = 0;
    int items_sent      = 0;
    int unused_seen     = 0;
    int results_checked = 0;
    int full_seen       = 0;
    int peak_held       = 0;
    int cycle_count     = 0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        rcv_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int slot_of_key(input logic [jst_pkg::PID_W-1:0] key);
        for (int i = 0; i < TBL_SLOTS; i++)
            if (tbl_used[i] && tbl_pid[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int slot_if_used(input logic [jst_pkg::SID_W-1:0] sid);
        if (int'(sid) < TBL_SLOTS && tbl_used[sid])
            return int'(sid);
        return -1;
    endfunction

    function automatic job_result_t table_apply(input logic [jst_pkg::CMD_W-1:0] op,
                                                input logic [jst_pkg::PID_W-1:0] key,
                                                input logic [jst_pkg::SID_W-1:0] sid);
        job_result_t r;
        int hit;
        int i;
        logic by_key;
        logic to_stop;
        r = '0;
        r.status = jst_pkg::ST_NONE;
        hit = -1;
        case (op)
            jst_pkg::CMD_ADD:
                if (tbl_held >= TBL_SLOTS || tbl_low_free >= TBL_SLOTS)
                    r.status = jst_pkg::ST_FULL;
                else
                begin
                    hit = tbl_low_free;
                    tbl_used[hit] = 1'b1;
                    tbl_pid[hit] = key;
                    tbl_stopped[hit] = 1'b0;
                    tbl_held++;
                    i = hit + 1;
                    while (i < TBL_SLOTS && tbl_used[i])
                        i++;
                    tbl_low_free = i;
                end
            jst_pkg::CMD_RM_SLOT, jst_pkg::CMD_RM_KEY:
            begin
                hit = (op == jst_pkg::CMD_RM_SLOT) ? slot_if_used(sid) : slot_of_key(key);
                // removal reports the entry as it was
                if (hit >= 0)
                begin
                    r.status = jst_pkg::ST_OK;
                    r.slot = jst_pkg::SID_W'(hit);
                    r.pid = tbl_pid[hit];
                    r.stopped = tbl_stopped[hit];
                    tbl_used[hit] = 1'b0;
                    tbl_stopped[hit] = 1'b0;
                    tbl_held--;
                    if (hit < tbl_low_free)
                        tbl_low_free = hit;
                end
                hit = -1;
            end
            jst_pkg::CMD_STOP_KEY, jst_pkg::CMD_RUN_KEY,
            jst_pkg::CMD_STOP_SLOT, jst_pkg::CMD_RUN_SLOT:
            begin
                by_key = (op == jst_pkg::CMD_STOP_KEY || op == jst_pkg::CMD_RUN_KEY);
                to_stop = (op == jst_pkg::CMD_STOP_KEY || op == jst_pkg::CMD_STOP_SLOT);
                hit = by_key ? slot_of_key(key) : slot_if_used(sid);
                if (hit >= 0)
                    tbl_stopped[hit] = to_stop;
            end
            jst_pkg::CMD_LOOK_SLOT:
                hit = slot_if_used(sid);
            jst_pkg::CMD_LOOK_KEY:
                hit = slot_of_key(key);
            jst_pkg::CMD_TOP, jst_pkg::CMD_TOP_STOP:
                for (i = 0; i < TBL_SLOTS; i++)
                    if (tbl_used[i] && (op == jst_pkg::CMD_TOP || tbl_stopped[i]))
                        hit = i;
            default:
                ;
        endcase
        if (hit >= 0)
        begin
            r.status = jst_pkg::ST_OK;
            r.slot = jst_pkg::SID_W'(hit);
            r.pid = tbl_pid[hit];
            r.stopped = tbl_stopped[hit];
        end
        r.held = jst_pkg::HELD_W'(tbl_held);
        return r;
    endfunction

    function automatic int pick_used_slot();
        int used_list [$];
        for (int i = 0; i < TBL_SLOTS; i++)
            if (tbl_used[i])
                used_list.push_back(i);
        if (used_list.size() == 0)
            return -1;
        return used_list[$urandom_range(used_list.size() - 1)];
    endfunction

    function automatic logic [jst_pkg::PID_W-1:0] pick_key();
        int s;
        int roll;
        s = pick_used_slot();
        roll = $urandom_range(99);
        if (s >= 0 && roll < 55)
            return tbl_pid[s];
        if (roll < 65)
            return ($urandom_range(1) != 0) ? PID_MAX : {jst_pkg::PID_W{1'b0}};
        if (roll < 75)
            return jst_pkg::PID_W'($urandom_range(15));
        return jst_pkg::PID_W'($urandom());
    endfunction

    function automatic logic [jst_pkg::SID_W-1:0] pick_slot();
        int s;
        int roll;
        s = pick_used_slot();
        roll = $urandom_range(99);
        if (s >= 0 && roll < 60)
            return jst_pkg::SID_W'(s);
        if (roll < 70)
            return ($urandom_range(1) != 0) ? SID_MAX : {jst_pkg::SID_W{1'b0}};
        return jst_pkg::SID_W'($urandom_range(TBL_SLOTS - 1));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, rsp_if.status, rsp_if.found_slot);
                errors++;
            end
            else
            begin
                want_res = results_due.pop_front();
                check_field("status", 32'(want_res.status), 32'(rsp_if.status));
                check_field("found_slot", 32'(want_res.slot), 32'(rsp_if.found_slot));
                check_field("found_pid", 32'(want_res.pid), 32'(rsp_if.found_pid));
                check_field("found_stopped", 32'(want_res.stopped), 32'(rsp_if.found_stopped));
                check_field("jobs_held", 32'(want_res.held), 32'(rsp_if.jobs_held));
                results_checked++;
                if (want_res.status == jst_pkg::ST_FULL)
                    full_seen++;
            end
        end
    end

    task automatic send_cmd(input logic [jst_pkg::CMD_W-1:0] op,
                            input logic [jst_pkg::PID_W-1:0] key,
                            input logic [jst_pkg::SID_W-1:0] sid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= op;
        cmd_if.job_pid <= key;
        cmd_if.slot_id <= sid;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        results_due.push_back(table_apply(op, key, sid));
        items_sent++;
        if (op > jst_pkg::CMD_TOP_STOP)
            unused_seen++;
        if (tbl_held > peak_held)
            peak_held = tbl_held;
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_cmd(jst_pkg::CMD_LOOK_SLOT, '0, '0);
        send_cmd(jst_pkg::CMD_LOOK_KEY, '0, '0);
        send_cmd(jst_pkg::CMD_TOP, PID_MAX, SID_MAX);
        send_cmd(jst_pkg::CMD_TOP_STOP, '0, '0);
        send_cmd(jst_pkg::CMD_RM_SLOT, PID_MAX, SID_MAX);
        send_cmd(jst_pkg::CMD_RM_KEY, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_STOP_SLOT, '0, 7'd5);
        send_cmd(jst_pkg::CMD_RUN_KEY, '0, '0);
    endtask

    task automatic test_add_and_slots();
        send_cmd(jst_pkg::CMD_ADD, '0, SID_MAX);
        send_cmd(jst_pkg::CMD_ADD, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_ADD, PID_MAX, '0);     // duplicate key
        send_cmd(jst_pkg::CMD_ADD, 22'h2AAAAA, '0);
        send_cmd(jst_pkg::CMD_LOOK_SLOT, '0, 7'd1);
        send_cmd(jst_pkg::CMD_STOP_SLOT, '0, 7'd2);
        send_cmd(jst_pkg::CMD_TOP_STOP, '0, '0);
        send_cmd(jst_pkg::CMD_RUN_SLOT, '0, 7'd2);
        send_cmd(jst_pkg::CMD_RM_SLOT, '0, 7'd1);
        send_cmd(jst_pkg::CMD_ADD, 22'h155555, '0);  // refills the hole
        send_cmd(jst_pkg::CMD_TOP, '0, '0);
    endtask

    task automatic test_key_ops();
        send_cmd(jst_pkg::CMD_STOP_KEY, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_LOOK_KEY, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_RM_KEY, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_LOOK_KEY, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_RUN_KEY, PID_MAX, '0);
        send_cmd(jst_pkg::CMD_RM_KEY, '0, '0);
        send_cmd(jst_pkg::CMD_RM_KEY, '0, '0);
    endtask

    task automatic test_unused_cmds();
        send_cmd(jst_pkg::CMD_W'(jst_pkg::CMD_TOP_STOP + 1), PID_MAX, SID_MAX);
        send_cmd(CMD_LAST_CODE, '0, '0);
    endtask

    task automatic test_fill_to_full();
        while (tbl_held < TBL_SLOTS)
            send_cmd(jst_pkg::CMD_ADD, pick_key(), pick_slot());
        send_cmd(jst_pkg::CMD_ADD, pick_key(), pick_slot());
        send_cmd(jst_pkg::CMD_ADD, PID_MAX, SID_MAX);
        send_cmd(jst_pkg::CMD_LOOK_SLOT, '0, SID_MAX);
        send_cmd(jst_pkg::CMD_STOP_SLOT, '0, SID_MAX);
        send_cmd(jst_pkg::CMD_TOP, '0, '0);
        send_cmd(jst_pkg::CMD_TOP_STOP, '0, '0);
        send_cmd(jst_pkg::CMD_RM_SLOT, '0, SID_MAX);
        send_cmd(jst_pkg::CMD_ADD, pick_key(), '0);  // lands in the top slot
    endtask

    task automatic test_random_mix(input int count);
        logic [jst_pkg::CMD_W-1:0] op;
        int roll;
        int add_pct;
        repeat (count)
        begin
            add_pct = (tbl_held > 96) ? 10 : 28;
            roll = $urandom_range(99);
            if (roll < add_pct)
                op = jst_pkg::CMD_ADD;
            else if (roll < add_pct + 3)
                op = jst_pkg::CMD_W'(jst_pkg::CMD_TOP_STOP + 1
                        + $urandom_range(CMD_LAST_CODE - jst_pkg::CMD_TOP_STOP - 1));
            else
                op = jst_pkg::CMD_W'(jst_pkg::CMD_RM_SLOT
                        + $urandom_range(jst_pkg::CMD_TOP_STOP - jst_pkg::CMD_RM_SLOT));
            send_cmd(op, pick_key(), pick_slot());
        end
    endtask

    initial
    begin
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= jst_pkg::CMD_ADD;
        cmd_if.job_pid <= '0;
        cmd_if.slot_id <= '0;
        for (int i = 0; i < TBL_SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_pid[i] = '0;
            tbl_stopped[i] = 1'b0;
        end
        tbl_held = 0;
        tbl_low_free = 0;
        send_idle_pct = 28;
        rcv_idle_pct <= 87;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_add_and_slots();
        test_key_ops();
        test_unused_cmds();
        test_fill_to_full();
        test_random_mix(190);
        drain_results();

        send_idle_pct = 87;
        rcv_idle_pct <= 28;
        test_random_mix(240);

        send_idle_pct = 0;
        rcv_idle_pct <= 0;
        test_fill_to_full();
        test_random_mix(140);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items (%0d with unused codes), %0d results checked",
                 items_sent, unused_seen, results_checked);
        $display("table-full answers %0d, peak occupancy %0d of %0d slots",
                 full_seen, peak_held, TBL_SLOTS);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== job_slot_table_core.f =====
sv/jst_pkg.sv
sv/jst_cmd_if.sv
sv/jst_rsp_if.sv
sv/jst_mem.sv
sv/job_slot_table_core.sv
tb/tb_job_slot_table_core.sv
